### sv/pqdk_pkg.sv
`default_nettype none

package pqdk_pkg;

    localparam int ID_W     = 6;
    localparam int PRIO_W   = 32;
    localparam int LIMIT_W  = 7;
    localparam int OPCODE_W = 2;

    localparam logic [LIMIT_W-1:0] ID_LIMIT_RST = 7'd64;

    typedef enum logic [OPCODE_W-1:0] {
        OP_INSERT   = 2'd0,
        OP_DECREASE = 2'd1,
        OP_REMOVE   = 2'd2,
        OP_QUERY    = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_SCAN,
        S_APPLY
    } t_state;

    // Per-cycle command broadcast to every cell of the chain.
    typedef struct packed {
        logic match;
        logic scan;
        logic ins;
        logic dec;
        logic rem;
    } t_cell_ctl;

endpackage

`default_nettype wire

### sv/pqdk_cell.sv
`default_nettype none

module pqdk_cell
    import pqdk_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_cell_ctl                i_ctl,
    input  wire logic [ID_W-1:0]          i_req_id,
    input  wire logic signed [PRIO_W-1:0] i_req_prio,
    input  wire logic                     i_left_valid,
    input  wire logic                     i_left_less,
    input  wire logic [ID_W-1:0]          i_left_id,
    input  wire logic signed [PRIO_W-1:0] i_left_prio,
    input  wire logic                     i_right_valid,
    input  wire logic [ID_W-1:0]          i_right_id,
    input  wire logic signed [PRIO_W-1:0] i_right_prio,
    input  wire logic                     i_right_sfx,
    input  wire logic signed [PRIO_W-1:0] i_right_fp,
    output logic                          o_valid,
    output logic [ID_W-1:0]               o_id,
    output logic signed [PRIO_W-1:0]      o_prio,
    output logic                          o_less,
    output logic                          o_sfx,
    output logic signed [PRIO_W-1:0]      o_fp
);

    logic                     r_valid, n_valid;
    logic [ID_W-1:0]          r_id, n_id;
    logic signed [PRIO_W-1:0] r_prio, n_prio;
    logic                     r_less, n_less;
    logic                     r_sfx, n_sfx;
    logic signed [PRIO_W-1:0] r_fp, n_fp;

    logic w_take_new;
    logic w_take_left;

    // The entry goes before all entries that are not smaller than it, so the
    // cell that sees a smaller left neighbor and is not smaller itself takes it.
    assign w_take_new  = (i_ctl.ins && i_left_less && !r_less)
                       || (i_ctl.dec && i_left_less && !r_less && r_sfx);
    assign w_take_left = (i_ctl.ins && !i_left_less && i_left_valid)
                       || (i_ctl.dec && !i_left_less && r_sfx);

    always_comb begin
        n_valid = r_valid;
        n_id    = r_id;
        n_prio  = r_prio;
        n_less  = r_less;
        n_sfx   = r_sfx;
        n_fp    = r_fp;
        if (i_ctl.match) begin
            n_sfx  = r_valid && (r_id == i_req_id);
            n_less = r_valid && (r_prio < i_req_prio);
            n_fp   = r_prio;
        end else if (i_ctl.scan) begin
            n_sfx = r_sfx | i_right_sfx;
            n_fp  = r_sfx ? r_fp : i_right_fp;
        end else if (i_ctl.rem) begin
            n_valid = i_right_valid;
            n_id    = i_right_id;
            n_prio  = i_right_prio;
        end else if (w_take_new) begin
            n_valid = 1'b1;
            n_id    = i_req_id;
            n_prio  = i_req_prio;
        end else if (w_take_left) begin
            n_valid = i_left_valid;
            n_id    = i_left_id;
            n_prio  = i_left_prio;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id   <= n_id;
        r_prio <= n_prio;
        r_less <= n_less;
        r_sfx  <= n_sfx;
        r_fp   <= n_fp;
    end

    assign o_valid = r_valid;
    assign o_id    = r_id;
    assign o_prio  = r_prio;
    assign o_less  = r_less;
    assign o_sfx   = r_sfx;
    assign o_fp    = r_fp;

endmodule

`default_nettype wire

### sv/priority_queue_decrease_key.sv
`default_nettype none

// Channel     Direction  Handshake                 Payload
// ---------   ---------  ------------------------  ---------------------------------------
// command     in         start high, busy low      i_opcode, i_entry_id, i_priority_req
// result      out        o_done (one cycle)        o_ok, o_out_id, o_out_priority,
//                                                  o_queue_size
// id limit    in         i_cfg_we                  i_cfg_data
//
// A remove transaction goes through the match and apply states before the next
// acceptance. Insert, decrease and query go through match, scan and apply: the id search
// is a wave that moves one cell per cycle from the tail of the chain to its head.
// The result strobe rises in the cycle in which busy falls again.
// Reset is synchronous and active low; it empties the queue and sets the id limit to 64.
// The receiver cannot stall results; each is shown for exactly one cycle.

module priority_queue_decrease_key
    import pqdk_pkg::*;
#(
    parameter  int CAPACITY = 64,
    localparam int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic [OPCODE_W-1:0]      i_opcode,
    input  wire logic [ID_W-1:0]          i_entry_id,
    input  wire logic signed [PRIO_W-1:0] i_priority_req,
    input  wire logic                     i_cfg_we,
    input  wire logic [LIMIT_W-1:0]       i_cfg_data,
    output logic                          o_done,
    output logic                          o_ok,
    output logic [ID_W-1:0]               o_out_id,
    output logic signed [PRIO_W-1:0]      o_out_priority,
    output logic [CNT_W-1:0]              o_queue_size
);

    localparam int SCAN_W = $clog2(CAPACITY);

    t_state                   r_state, n_state;
    logic [SCAN_W-1:0]        r_scan_cnt, n_scan_cnt;
    logic [CNT_W-1:0]         r_count, n_count;
    logic [LIMIT_W-1:0]       r_id_limit;
    t_opcode                  r_req_op;
    logic [ID_W-1:0]          r_req_id;
    logic signed [PRIO_W-1:0] r_req_prio;

    t_cell_ctl w_ctl;

    // Chain taps, one per cell.
    logic [CAPACITY-1:0]      w_valid;
    logic [CAPACITY-1:0]      w_less;
    logic [CAPACITY-1:0]      w_sfx;
    logic [ID_W-1:0]          w_id [CAPACITY];
    logic signed [PRIO_W-1:0] w_prio [CAPACITY];
    logic signed [PRIO_W-1:0] w_fp [CAPACITY];

    logic                     w_accept;
    logic                     w_scan_last;
    logic                     w_in_range;
    logic                     w_found;
    logic signed [PRIO_W-1:0] w_found_prio;
    logic                     w_ins_ok;
    logic                     w_dec_ok;
    logic                     w_rem_ok;
    logic                     w_qry_ok;
    logic                     w_res_ok;
    logic [ID_W-1:0]          w_res_id;
    logic signed [PRIO_W-1:0] w_res_prio;

    assign busy        = (r_state != S_IDLE);
    assign w_accept    = start && !busy;
    assign w_scan_last = (r_scan_cnt == SCAN_W'(CAPACITY - 2));

    // After the scan wave the head cell holds whether the id is present anywhere in
    // the chain, and the priority of the entry that carries it.
    assign w_found      = w_sfx[0];
    assign w_found_prio = w_fp[0];
    assign w_in_range   = ({1'b0, r_req_id} < r_id_limit);

    assign w_ins_ok = (r_req_op == OP_INSERT) && w_in_range && !w_found
                    && (r_count < CNT_W'(CAPACITY));
    assign w_dec_ok = (r_req_op == OP_DECREASE) && w_in_range && w_found
                    && (r_req_prio < w_found_prio);
    assign w_qry_ok = (r_req_op == OP_QUERY) && w_in_range && w_found;
    assign w_rem_ok = (r_req_op == OP_REMOVE) && (r_count != '0);
    assign w_res_ok = w_ins_ok || w_dec_ok || w_qry_ok || w_rem_ok;

    always_comb begin
        w_res_id   = r_req_id;
        w_res_prio = '0;
        if (r_req_op == OP_REMOVE) begin
            w_res_id = w_rem_ok ? w_id[0] : '0;
            if (w_rem_ok) begin
                w_res_prio = w_prio[0];
            end
        end else if (w_qry_ok) begin
            w_res_prio = w_found_prio;
        end
    end

    // Next-state logic of the sequencer.
    always_comb begin
        n_state    = r_state;
        n_scan_cnt = r_scan_cnt;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_MATCH;
                end
            end
            S_MATCH: begin
                n_scan_cnt = '0;
                n_state    = (r_req_op == OP_REMOVE) ? S_APPLY : S_SCAN;
            end
            S_SCAN: begin
                n_scan_cnt = r_scan_cnt + 1'b1;
                if (w_scan_last) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Commands to the chain for each sequencer state.
    always_comb begin
        w_ctl = '0;
        case (r_state)
            S_MATCH: begin
                w_ctl.match = 1'b1;
            end
            S_SCAN: begin
                w_ctl.scan = 1'b1;
            end
            S_APPLY: begin
                w_ctl.ins = w_ins_ok;
                w_ctl.dec = w_dec_ok;
                w_ctl.rem = w_rem_ok;
            end
            default: begin
                w_ctl = '0;
            end
        endcase
    end

    always_comb begin
        n_count = r_count;
        if (r_state == S_APPLY) begin
            if (w_ins_ok) begin
                n_count = r_count + 1'b1;
            end else if (w_rem_ok) begin
                n_count = r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_scan_cnt <= '0;
            r_count    <= '0;
            r_id_limit <= ID_LIMIT_RST;
            o_done     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_scan_cnt <= n_scan_cnt;
            r_count    <= n_count;
            o_done     <= (r_state == S_APPLY);
            if (i_cfg_we) begin
                r_id_limit <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req_op   <= t_opcode'(i_opcode);
            r_req_id   <= i_entry_id;
            r_req_prio <= i_priority_req;
        end
        if (r_state == S_APPLY) begin
            o_ok           <= w_res_ok;
            o_out_id       <= w_res_id;
            o_out_priority <= w_res_prio;
        end
    end

    assign o_queue_size = r_count;

    // The sorted chain. Cell 0 holds the minimum. The head sees a smaller, empty
    // left neighbor and the tail an empty right neighbor.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic                     w_l_valid;
        logic                     w_l_less;
        logic [ID_W-1:0]          w_l_id;
        logic signed [PRIO_W-1:0] w_l_prio;
        logic                     w_r_valid;
        logic [ID_W-1:0]          w_r_id;
        logic signed [PRIO_W-1:0] w_r_prio;
        logic                     w_r_sfx;
        logic signed [PRIO_W-1:0] w_r_fp;

        if (g == 0) begin : g_head
            assign w_l_valid = 1'b0;
            assign w_l_less  = 1'b1;
            assign w_l_id    = '0;
            assign w_l_prio  = '0;
        end else begin : g_mid_l
            assign w_l_valid = w_valid[g-1];
            assign w_l_less  = w_less[g-1];
            assign w_l_id    = w_id[g-1];
            assign w_l_prio  = w_prio[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_r_valid = 1'b0;
            assign w_r_id    = '0;
            assign w_r_prio  = '0;
            assign w_r_sfx   = 1'b0;
            assign w_r_fp    = '0;
        end else begin : g_mid_r
            assign w_r_valid = w_valid[g+1];
            assign w_r_id    = w_id[g+1];
            assign w_r_prio  = w_prio[g+1];
            assign w_r_sfx   = w_sfx[g+1];
            assign w_r_fp    = w_fp[g+1];
        end

        pqdk_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_req_id     (r_req_id),
            .i_req_prio   (r_req_prio),
            .i_left_valid (w_l_valid),
            .i_left_less  (w_l_less),
            .i_left_id    (w_l_id),
            .i_left_prio  (w_l_prio),
            .i_right_valid(w_r_valid),
            .i_right_id   (w_r_id),
            .i_right_prio (w_r_prio),
            .i_right_sfx  (w_r_sfx),
            .i_right_fp   (w_r_fp),
            .o_valid      (w_valid[g]),
            .o_id         (w_id[g]),
            .o_prio       (w_prio[g]),
            .o_less       (w_less[g]),
            .o_sfx        (w_sfx[g]),
            .o_fp         (w_fp[g])
        );
    end

`ifndef SYNTHESIS
    a_done_after_apply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == S_APPLY))
        else $error("result strobe without a completed operation");

    a_count_matches_cells: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == int'(r_count))
        else $error("occupied cells disagree with the entry count");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    a_count_moves_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_count != $past(r_count))) |-> o_done)
        else $error("entry count changed outside a completed operation");

    a_accept_starts_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_MATCH))
        else $error("accepted transaction did not enter the match phase");
`endif

endmodule

`default_nettype wire
